// ----- sv/tot_pkg.sv -----
// ----------------------------------------------------------------------------
// Tiered over-current trip package
// Field widths, register indexes, reset values and the result layout.
// ----------------------------------------------------------------------------
package tot_pkg;

   localparam int TIME_W     = 48;
   localparam int CUR_W      = 16;
   localparam int PERIOD_W   = 20;
   localparam int THR_W      = 16;
   localparam int DWELL_W    = 24;
   localparam int SUM_W      = 20;
   localparam int CNT_W      = 4;
   localparam int TIER_W     = 2;
   localparam int MAX_TIERS  = 3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 24;

   // Register indexes: the sample period, then a threshold and dwell pair per tier.
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_PERIOD = 3'd0;
   localparam int CSR_TIER_BASE   = 1;
   localparam int CSR_TIER_STRIDE = 2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd5000;
   localparam logic [THR_W-1:0]    THR_RESET   [MAX_TIERS] = '{16'd20000, 16'd15000, 16'd10000};
   localparam logic [DWELL_W-1:0]  DWELL_RESET [MAX_TIERS] = '{24'd0, 24'd500000, 24'd2000000};

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_RELAY  = 1'b1;

   // First member sits in the highest bits, so the list runs from the top down.
   typedef struct packed {
      logic [1:0]        pad;
      logic              window_done;
      logic [CUR_W-1:0]  trip_current_ma;
      logic [TIER_W-1:0] trip_tier;
      logic              trip_event;
      logic              tripped;
      logic              rail_enabled;
   } rsp_fields_type;

endpackage

// ----- sv/tiered_overcurrent_trip_top.sv -----
// ----------------------------------------------------------------------------
// Tiered over-current trip
// Averages accepted rail current samples over a window, checks each tier's
// threshold and dwell time, and latches a trip that drops the rail.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Contents
//  --------+-----------+--------------------+-------------------------------------
//  req_    | in        | tvalid/tready      | tuser: action; tdata: time, current, relay
//  rsp_    | out       | tvalid/tready      | tdata: one result per item
//  csr_    | in        | write enable only  | register index and write data
//
// One item per clock when the result side keeps up. An item is registered on
// transfer and evaluated once the result register can take it, against the
// state, which is updated at the same edge that loads the result register.
// A stall on rsp_ holds the result and the input register; req_tready drops
// only when both are full. Reset is synchronous and loads the register defaults.
//
module tiered_overcurrent_trip_top
   import tot_pkg::*;
#(
   parameter int TIER_COUNT  = 3,
   parameter int AVG_SAMPLES = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [47:0] time_us, [63:48] current_ma, [64] relay_on, [71:65] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] rail_enabled, [1] tripped, [2] trip_event, [4:3] trip_tier,
   // [20:5] trip_current_ma, [21] window_done, [23:22] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Thresholds are kept pre-scaled by the window length so the average
   // compare works on the raw sum.
   localparam int SCALED_W  = THR_W + $clog2(AVG_SAMPLES) + 1;
   localparam int SHIFT     = SUM_W + $clog2(AVG_SAMPLES);
   localparam int RECIP_W   = SHIFT + 1;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));
   localparam logic [CNT_W-1:0] WINDOW_LEN = CNT_W'(AVG_SAMPLES);

   // Configuration
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [SCALED_W-1:0] thr_scaled_ff [TIER_COUNT];
   logic [SCALED_W-1:0] thr_scaled_in [TIER_COUNT];
   logic [DWELL_W-1:0]  dwell_ff [TIER_COUNT];
   logic [DWELL_W-1:0]  dwell_in [TIER_COUNT];

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic              in_action_ff, in_action_in;
   logic [TIME_W-1:0] in_time_ff, in_time_in;
   logic [CUR_W-1:0]  in_current_ff, in_current_in;
   logic              in_relay_ff, in_relay_in;

   // Protection state
   logic              rail_on_ff, rail_on_in;
   logic              trip_ff, trip_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              armed_ff [TIER_COUNT];
   logic              armed_in [TIER_COUNT];
   logic [TIME_W-1:0] start_ff [TIER_COUNT];
   logic [TIME_W-1:0] start_in [TIER_COUNT];
   logic [TIER_W-1:0] ltier_ff, ltier_in;
   logic [CUR_W-1:0]  lcur_ff, lcur_in;

   // Result register
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_fields_type rsp_ff, rsp_in;

   logic                     advance;
   logic                     fire;
   logic                     req_xfer;
   logic [SUM_W-1:0]         sum_next;
   logic [CNT_W-1:0]         count_next;
   logic [SUM_W+RECIP_W-1:0] avg_product;
   logic [SUM_W-1:0]         avg;
   logic [TIME_W-1:0]        since_last;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign sum_next    = SUM_W'(sum_ff + SUM_W'(in_current_ff));
   assign count_next  = CNT_W'(count_ff + 1'b1);
   assign avg_product = (SUM_W+RECIP_W)'(sum_next) * (SUM_W+RECIP_W)'(AVG_RECIP);
   assign avg         = avg_product[SHIFT +: SUM_W];
   assign since_last  = TIME_W'(in_time_ff - last_time_ff);

   always_comb begin
      logic              hit;
      logic              tier_trip;
      logic [TIME_W-1:0] elapsed;

      hit       = 1'b0;
      tier_trip = 1'b0;
      elapsed   = '0;

      // Configuration writes
      period_in = period_ff;
      for (int k = 0; k < TIER_COUNT; k++) begin
         thr_scaled_in[k] = thr_scaled_ff[k];
         dwell_in[k]      = dwell_ff[k];
      end
      if (csr_we) begin
         if (csr_addr == CSR_SAMPLE_PERIOD) begin
            period_in = csr_wdata[PERIOD_W-1:0];
         end
         for (int k = 0; k < TIER_COUNT; k++) begin
            if (csr_addr == CSR_ADDR_W'(CSR_TIER_BASE + CSR_TIER_STRIDE * k)) begin
               thr_scaled_in[k] = SCALED_W'(csr_wdata[THR_W-1:0]) * SCALED_W'(AVG_SAMPLES);
            end
            if (csr_addr == CSR_ADDR_W'(CSR_TIER_BASE + CSR_TIER_STRIDE * k + 1)) begin
               dwell_in[k] = csr_wdata[DWELL_W-1:0];
            end
         end
      end

      // Input register
      in_valid_in   = req_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      in_action_in  = req_xfer ? req_tuser : in_action_ff;
      in_time_in    = req_xfer ? req_tdata[TIME_W-1:0] : in_time_ff;
      in_current_in = req_xfer ? req_tdata[TIME_W +: CUR_W] : in_current_ff;
      in_relay_in   = req_xfer ? req_tdata[TIME_W + CUR_W] : in_relay_ff;

      // State holds unless an item is evaluated
      rail_on_in   = rail_on_ff;
      trip_in      = trip_ff;
      last_time_in = last_time_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ltier_in     = ltier_ff;
      lcur_in      = lcur_ff;
      for (int k = 0; k < TIER_COUNT; k++) begin
         armed_in[k] = armed_ff[k];
         start_in[k] = start_ff[k];
      end

      rsp_in             = '0;
      rsp_in.window_done = 1'b0;
      rsp_in.trip_event  = 1'b0;

      if (fire) begin
         if (in_action_ff == ACTION_RELAY) begin
            trip_in  = 1'b0;
            ltier_in = '0;
            lcur_in  = '0;
            rail_on_in = in_relay_ff;
            if (in_relay_ff) begin
               sum_in   = '0;
               count_in = '0;
               for (int k = 0; k < TIER_COUNT; k++) begin
                  armed_in[k] = 1'b0;
               end
            end
         end else if (!trip_ff) begin
            if (!rail_on_ff) begin
               sum_in   = '0;
               count_in = '0;
               for (int k = 0; k < TIER_COUNT; k++) begin
                  armed_in[k] = 1'b0;
               end
            end else if (since_last >= TIME_W'(period_ff)) begin
               last_time_in = in_time_ff;
               if (count_next >= WINDOW_LEN) begin
                  sum_in             = '0;
                  count_in           = '0;
                  rsp_in.window_done = 1'b1;
                  // Tiers are checked in order; the first to trip ends the scan.
                  for (int k = 0; k < TIER_COUNT; k++) begin
                     if (!hit) begin
                        if (SCALED_W'(sum_next) >= thr_scaled_ff[k]) begin
                           elapsed   = TIME_W'(in_time_ff - start_ff[k]);
                           tier_trip = armed_ff[k] ? (elapsed >= TIME_W'(dwell_ff[k]))
                                                   : (dwell_ff[k] == '0);
                           if (!armed_ff[k]) begin
                              armed_in[k] = 1'b1;
                              start_in[k] = in_time_ff;
                           end
                           if (tier_trip) begin
                              hit               = 1'b1;
                              trip_in           = 1'b1;
                              ltier_in          = TIER_W'(k);
                              lcur_in           = avg[CUR_W-1:0];
                              rail_on_in        = 1'b0;
                              rsp_in.trip_event = 1'b1;
                           end
                        end else begin
                           armed_in[k] = 1'b0;
                        end
                     end
                  end
               end else begin
                  sum_in   = sum_next;
                  count_in = count_next;
               end
            end
         end
      end

      rsp_in.rail_enabled    = rail_on_in;
      rsp_in.tripped         = trip_in;
      rsp_in.trip_tier       = trip_in ? ltier_in : '0;
      rsp_in.trip_current_ma = trip_in ? lcur_in : '0;

      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      if (!fire) begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         in_valid_ff  <= 1'b0;
         rail_on_ff   <= 1'b0;
         trip_ff      <= 1'b0;
         last_time_ff <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         ltier_ff     <= '0;
         lcur_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < TIER_COUNT; k++) begin
            thr_scaled_ff[k] <= SCALED_W'(THR_RESET[k]) * SCALED_W'(AVG_SAMPLES);
            dwell_ff[k]      <= DWELL_RESET[k];
            armed_ff[k]      <= 1'b0;
         end
      end else begin
         period_ff    <= period_in;
         in_valid_ff  <= in_valid_in;
         rail_on_ff   <= rail_on_in;
         trip_ff      <= trip_in;
         last_time_ff <= last_time_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ltier_ff     <= ltier_in;
         lcur_ff      <= lcur_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < TIER_COUNT; k++) begin
            thr_scaled_ff[k] <= thr_scaled_in[k];
            dwell_ff[k]      <= dwell_in[k];
            armed_ff[k]      <= armed_in[k];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_action_ff  <= in_action_in;
      in_time_ff    <= in_time_in;
      in_current_ff <= in_current_in;
      in_relay_ff   <= in_relay_in;
      rsp_ff        <= rsp_in;
      for (int k = 0; k < TIER_COUNT; k++) begin
         start_ff[k] <= start_in[k];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // A latched trip always keeps the rail off.
   a_trip_rail_off: assert property (@(posedge clock) disable iff (reset)
      trip_ff |-> !rail_on_ff)
      else $error("rail enabled while a trip is latched");

   // The window count never reaches the window length between items.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < WINDOW_LEN)
      else $error("window count out of range");

   // A reported trip event comes with the latch set and the rail dropped.
   a_event_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.trip_event |-> rsp_ff.tripped && !rsp_ff.rail_enabled)
      else $error("trip event without latch");

   // The input side only stalls when both stages are full and the output is held.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without back-pressure");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tiered over-current trip testbench
// Walks a short table of hand-picked items, then runs phases of random sample
// and relay traffic under several register settings. Every result is checked
// field by field against a table row's status or a behavioral trip model kept here.
// ----------------------------------------------------------------------------
module tb;
   import tot_pkg::*;

   localparam int TIERS      = 3;
   localparam int AVG_LEN    = 10;
   localparam int PLAN_ROWS  = 20;
   localparam int PHASES     = 8;
   localparam int PHASE_LEN  = 212;
   localparam int PERIOD_MAX = 1000000;

   typedef struct {
      logic              act;
      logic [TIME_W-1:0] t_us;
      logic [CUR_W-1:0]  ma;
      logic              relay;
      logic              typed;
      rsp_fields_type    want;
   } plan_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Model copy of the registers.
   logic [PERIOD_W-1:0] period_cfg = PERIOD_RESET;
   logic [THR_W-1:0]    thr_cfg   [MAX_TIERS] = THR_RESET;
   logic [DWELL_W-1:0]  dwell_cfg [MAX_TIERS] = DWELL_RESET;

   // Model copy of the protection state.
   logic              rail_up      = 1'b0;
   logic              trip_held    = 1'b0;
   logic [TIME_W-1:0] last_take_us = '0;
   logic [SUM_W-1:0]  acc_sum      = '0;
   logic [CNT_W-1:0]  acc_cnt      = '0;
   logic [TIME_W-1:0] arm_since_us [MAX_TIERS] = '{default: '0};
   logic              armed        [MAX_TIERS] = '{default: 1'b0};
   logic [TIER_W-1:0] held_tier    = '0;
   logic [CUR_W-1:0]  held_ma      = '0;

   rsp_fields_type expected_status_q [$];
   int             mismatch_count = 0;
   logic           gaps_on = 1'b0;
   int             stall_left = 0;

   tiered_overcurrent_trip_top #(
      .TIER_COUNT  (TIERS),
      .AVG_SAMPLES (AVG_LEN)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic rsp_fields_type status_word(logic rail, logic trip, logic ev,
         logic [TIER_W-1:0] tier, logic [CUR_W-1:0] ma, logic done);
      rsp_fields_type s;
      s = '0;
      s.rail_enabled    = rail;
      s.tripped         = trip;
      s.trip_event      = ev;
      s.trip_tier       = tier;
      s.trip_current_ma = ma;
      s.window_done     = done;
      return s;
   endfunction

   function automatic void clear_window();
      int k;
      for (k = 0; k < MAX_TIERS; k++) begin
         armed[k]        = 1'b0;
         arm_since_us[k] = '0;
      end
      acc_sum = '0;
      acc_cnt = '0;
   endfunction

   // Applies one item to the model state and returns the status it should produce.
   function automatic rsp_fields_type advance_protection(logic act, logic [TIME_W-1:0] now,
         logic [CUR_W-1:0] cur, logic want_on);
      rsp_fields_type   r;
      logic [CUR_W-1:0] avg;
      logic             scanning;
      int               k;
      r = '0;
      if (act == ACTION_RELAY) begin
         trip_held = 1'b0;
         held_tier = '0;
         held_ma   = '0;
         rail_up   = want_on;
         if (want_on) clear_window();
      end else if (!trip_held) begin
         if (!rail_up) begin
            clear_window();
         end else if (now - last_take_us >= period_cfg) begin
            last_take_us = now;
            acc_sum      = acc_sum + cur;
            acc_cnt      = acc_cnt + 1'b1;
            if (acc_cnt >= AVG_LEN) begin
               avg           = CUR_W'(acc_sum / AVG_LEN);
               acc_sum       = '0;
               acc_cnt       = '0;
               r.window_done = 1'b1;
               scanning      = 1'b1;
               // Only tiers up to the one that trips are looked at.
               for (k = 0; k < TIERS; k++) begin
                  if (scanning) begin
                     if (avg >= thr_cfg[k]) begin
                        if (!armed[k]) begin
                           armed[k]        = 1'b1;
                           arm_since_us[k] = now;
                        end
                        if (now - arm_since_us[k] >= dwell_cfg[k]) begin
                           trip_held    = 1'b1;
                           held_tier    = TIER_W'(k);
                           held_ma      = avg;
                           rail_up      = 1'b0;
                           r.trip_event = 1'b1;
                           scanning     = 1'b0;
                        end
                     end else begin
                        armed[k]        = 1'b0;
                        arm_since_us[k] = '0;
                     end
                  end
               end
            end
         end
      end
      r.rail_enabled    = rail_up;
      r.tripped         = trip_held;
      r.trip_tier       = trip_held ? held_tier : '0;
      r.trip_current_ma = trip_held ? held_ma : '0;
      return r;
   endfunction

   task automatic send_item(logic act, logic [TIME_W-1:0] t_us, logic [CUR_W-1:0] ma,
         logic relay, logic typed, rsp_fields_type want);
      rsp_fields_type predicted;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'b0, relay, ma, t_us};
      do @(posedge clock); while (!req_tready);
      predicted = advance_protection(act, t_us, ma, relay);
      expected_status_q.push_back(typed ? want : predicted);
   endtask

   // Waits until every transfer in flight has produced its result, or until the loop limit is reached.
   task automatic drain_status();
      int n;
      req_tvalid <= 1'b0;
      for (n = 0; n < 5000 && expected_status_q.size() != 0; n++) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_settings();
      int k;
      csr_we    <= 1'b1;
      csr_addr  <= CSR_SAMPLE_PERIOD;
      csr_wdata <= CSR_DATA_W'(period_cfg);
      @(posedge clock);
      for (k = 0; k < MAX_TIERS; k++) begin
         csr_addr  <= CSR_ADDR_W'(CSR_TIER_BASE + CSR_TIER_STRIDE * k);
         csr_wdata <= CSR_DATA_W'(thr_cfg[k]);
         @(posedge clock);
         csr_addr  <= CSR_ADDR_W'(CSR_TIER_BASE + CSR_TIER_STRIDE * k + 1);
         csr_wdata <= dwell_cfg[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watch_status
      rsp_fields_type want;
      rsp_fields_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_status_q.size() == 0) begin
            $display("%0t: unexpected result transfer, actual %0h", $time, got);
            mismatch_count++;
         end else begin
            want = expected_status_q.pop_front();
            compare_field("rail_enabled", want.rail_enabled, got.rail_enabled);
            compare_field("tripped", want.tripped, got.tripped);
            compare_field("trip_event", want.trip_event, got.trip_event);
            compare_field("trip_tier", want.trip_tier, got.trip_tier);
            compare_field("trip_current_ma", want.trip_current_ma, got.trip_current_ma);
            compare_field("window_done", want.window_done, got.window_done);
            compare_field("pad", want.pad, got.pad);
         end
      end
   end

   initial begin : stimulus
      plan_row_type      plan [PLAN_ROWS];
      rsp_fields_type    none;
      logic [TIME_W-1:0] time_now;
      logic [TIME_W-1:0] dt;
      logic [CUR_W-1:0]  ma;
      logic              act;
      logic              want_on;
      logic              ignored;
      int                i;
      int                p;
      int                n;
      int                k;
      int                v;
      int                level_ma;

      none = '0;
      // Rail off, the instant trip on a full-scale window, a sample while latched,
      // the clear by relay command and a timestamp that wraps around.
      plan = '{
         '{ACTION_SAMPLE, 48'd0,     16'hFFFF, 1'b0, 1'b1, status_word(0, 0, 0, 0, 0, 0)},
         '{ACTION_RELAY,  48'd50,    16'h0000, 1'b0, 1'b1, status_word(0, 0, 0, 0, 0, 0)},
         '{ACTION_RELAY,  48'd100,   16'h0000, 1'b1, 1'b1, status_word(1, 0, 0, 0, 0, 0)},
         '{ACTION_SAMPLE, 48'd10000, 16'hFFFF, 1'b0, 1'b0, none},
         '{ACTION_SAMPLE, 48'd12000, 16'hFFFF, 1'b1, 1'b0, none},
         '{ACTION_SAMPLE, 48'd15000, 16'hFFFF, 1'b0, 1'b0, none},
         '{ACTION_SAMPLE, 48'd20000, 16'hFFFF, 1'b0, 1'b0, none},
         '{ACTION_SAMPLE, 48'd25000, 16'hFFFF, 1'b0, 1'b0, none},
         '{ACTION_SAMPLE, 48'd30000, 16'hFFFF, 1'b0, 1'b0, none},
         '{ACTION_SAMPLE, 48'd35000, 16'hFFFF, 1'b0, 1'b0, none},
         '{ACTION_SAMPLE, 48'd40000, 16'hFFFF, 1'b0, 1'b0, none},
         '{ACTION_SAMPLE, 48'd45000, 16'hFFFF, 1'b0, 1'b0, none},
         '{ACTION_SAMPLE, 48'd50000, 16'hFFFF, 1'b0, 1'b0, none},
         '{ACTION_SAMPLE, 48'd55000, 16'hFFFF, 1'b0, 1'b1, status_word(0, 1, 1, 0, 16'hFFFF, 1)},
         '{ACTION_SAMPLE, 48'd60000, 16'hFFFF, 1'b0, 1'b1, status_word(0, 1, 0, 0, 16'hFFFF, 0)},
         '{ACTION_RELAY,  48'd61000, 16'h0000, 1'b1, 1'b1, status_word(1, 0, 0, 0, 0, 0)},
         '{ACTION_SAMPLE, 48'hFFFF_FFFF_FC18, 16'd1234, 1'b0, 1'b0, none},
         '{ACTION_SAMPLE, 48'd4000,  16'h0000, 1'b1, 1'b0, none},
         '{ACTION_RELAY,  48'd4100,  16'h0000, 1'b0, 1'b1, status_word(0, 0, 0, 0, 0, 0)},
         '{ACTION_SAMPLE, 48'd9000,  16'hFFFF, 1'b0, 1'b1, status_word(0, 0, 0, 0, 0, 0)}
      };

      repeat (8) @(posedge clock);
      reset   <= 1'b0;
      gaps_on <= 1'b1;
      @(posedge clock);
      for (i = 0; i < PLAN_ROWS; i++)
         send_item(plan[i].act, plan[i].t_us, plan[i].ma, plan[i].relay, plan[i].typed,
                   plan[i].want);
      drain_status();

      level_ma = 0;
      for (p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            period_cfg = '0;
            for (k = 0; k < MAX_TIERS; k++) begin
               thr_cfg[k]   = '0;
               dwell_cfg[k] = '0;
            end
         end else if (p == 1) begin
            period_cfg = PERIOD_W'(PERIOD_MAX);
            for (k = 0; k < MAX_TIERS; k++) begin
               thr_cfg[k]   = '1;
               dwell_cfg[k] = '1;
            end
         end else begin
            period_cfg = PERIOD_W'($urandom_range(0, 4000));
            for (k = 0; k < MAX_TIERS; k++) begin
               thr_cfg[k]   = THR_W'($urandom_range(1000, 60000));
               dwell_cfg[k] = DWELL_W'($urandom_range(0, 25 * (period_cfg + 1)));
            end
         end
         push_settings();
         // The final phase runs with both sides at full rate.
         gaps_on  <= (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         time_now = TIME_W'({$urandom, $urandom});
         n = 0;
         while (n < PHASE_LEN) begin
            if (trip_held)
               act = ($urandom_range(0, 2) != 0) ? ACTION_RELAY : ACTION_SAMPLE;
            else if (!rail_up)
               act = ($urandom_range(0, 3) != 0) ? ACTION_RELAY : ACTION_SAMPLE;
            else
               act = ($urandom_range(0, 29) == 0) ? ACTION_RELAY : ACTION_SAMPLE;
            ignored = (act == ACTION_SAMPLE) && trip_held;
            if (act == ACTION_RELAY) begin
               want_on = $urandom_range(0, 4) != 0;
               ma      = CUR_W'($urandom);
               time_now = time_now + TIME_W'($urandom_range(0, 50));
            end else begin
               want_on = 1'($urandom_range(0, 1));
               if ($urandom_range(0, 99) == 0)
                  dt = TIME_W'({$urandom, $urandom});
               else if ($urandom_range(0, 6) == 0)
                  dt = TIME_W'($urandom_range(0, period_cfg));
               else
                  dt = TIME_W'(period_cfg)
                     + TIME_W'($urandom_range(0, period_cfg / 4 + 5));
               time_now = time_now + dt;
               // A new window aims its average at one of the thresholds or anywhere.
               if (acc_cnt == 0) begin
                  k = $urandom_range(0, 3);
                  level_ma = (k < MAX_TIERS) ? int'(thr_cfg[k]) : int'($urandom_range(0, 65535));
               end
               if ($urandom_range(0, 19) == 0) begin
                  ma = CUR_W'($urandom);
               end else begin
                  v = level_ma + int'($urandom_range(0, 1600)) - 800;
                  if (v < 0) v = 0;
                  if (v > 65535) v = 65535;
                  ma = CUR_W'(v);
               end
            end
            send_item(act, time_now, ma, want_on, 1'b0, none);
            if (!ignored) n++;
         end
         drain_status();
      end

      if (expected_status_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_status_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
